// ----- hdl/bpq_pkg.sv -----
// ----------------------------------------------------------------------------
// bpq_pkg: shared types and constants for the bounded priority queue
// Field widths, default sizes, status and operation codes, cell control.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int PRI_BITS_DEF = 15;
  localparam int TAG_BITS_DEF = 32;

  localparam int CAP_W    = 5;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // per-cell control from the queue controller
  typedef struct packed {
    logic ins;       // accepted insert that fits
    logic rem;       // accepted remove of a stored entry
    logic occ;       // this cell holds an entry
    logic left_occ;  // left neighbor holds an entry (true for the head cell)
    logic first;     // head cell
    logic left_ge;   // left neighbor priority >= new priority
  } cell_ctrl_t;

endpackage

// ----- hdl/bpq_if.sv -----
// ----------------------------------------------------------------------------
// bpq_if: channel interfaces of the bounded priority queue
// Operation, result and capacity write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bpq_in_if import bpq_pkg::*; #(
  parameter int PRI_W = PRI_BITS_DEF,
  parameter int TAG_W = TAG_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [PRI_W-1:0] entry_priority;
  logic [TAG_W-1:0] entry_tag;

  modport source (output valid, opcode, entry_priority, entry_tag, input ready);
  modport sink   (input valid, opcode, entry_priority, entry_tag, output ready);
endinterface

interface bpq_out_if import bpq_pkg::*; #(
  parameter int PRI_W = PRI_BITS_DEF,
  parameter int TAG_W = TAG_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    out_tag;
  logic [PRI_W-1:0]    out_priority;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, out_tag, out_priority, entry_count, input ready);
  modport sink   (input valid, status, out_tag, out_priority, entry_count, output ready);
endinterface

interface bpq_cfg_if import bpq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hdl/bpq_cell.sv -----
// ----------------------------------------------------------------------------
// bpq_cell: one slot of the sorted insertion chain
// Keeps its entry, loads the new entry, or shifts from a neighbor.
// ----------------------------------------------------------------------------
module bpq_cell import bpq_pkg::*; #(
  parameter int PRI_W = PRI_BITS_DEF,
  parameter int TAG_W = TAG_BITS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  cell_ctrl_t       ctrl,
  input  logic [PRI_W-1:0] new_pri,
  input  logic [TAG_W-1:0] new_tag,
  input  logic [PRI_W-1:0] left_pri,
  input  logic [TAG_W-1:0] left_tag,
  input  logic [PRI_W-1:0] right_pri,
  input  logic [TAG_W-1:0] right_tag,
  output logic [PRI_W-1:0] pri,
  output logic [TAG_W-1:0] tag,
  output logic             ge
);

  logic [PRI_W-1:0] pri_r, pri_nxt;
  logic [TAG_W-1:0] tag_r, tag_nxt;
  logic             load_new, take_left;

  assign ge = ctrl.occ && (pri_r >= new_pri);

  // the insert point is the first cell not ranked ahead of the new entry
  assign load_new  = !ge && ctrl.left_occ && (ctrl.first || ctrl.left_ge);
  assign take_left = !ge && ctrl.left_occ && !ctrl.first && !ctrl.left_ge;

  always_comb begin
    pri_nxt = pri_r;
    tag_nxt = tag_r;
    if (ctrl.rem) begin
      pri_nxt = right_pri;
      tag_nxt = right_tag;
    end else if (ctrl.ins) begin
      if (load_new) begin
        pri_nxt = new_pri;
        tag_nxt = new_tag;
      end else if (take_left) begin
        pri_nxt = left_pri;
        tag_nxt = left_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pri_r <= pri_nxt;
      tag_r <= tag_nxt;
    end
  end

  assign pri = pri_r;
  assign tag = tag_r;

endmodule

// ----- hdl/bounded_priority_queue.sv -----
// The result of an operation is registered and valid in the cycle after acceptance.
// One operation per cycle unless stalled; every slot compares against the new priority
// at once and shifts by one position with its neighbor, so no operation iterates.
// Reset: entry count and output valid clear, capacity returns to 10; slot contents
// are not reset and are only read below the entry count.
// ----------------------------------------------------------------------------
// bounded_priority_queue: stable bounded priority queue of command tags
// Controller, capacity register and output register around a row of slot cells.
// ----------------------------------------------------------------------------
module bounded_priority_queue import bpq_pkg::*; #(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PRIORITY_BITS = PRI_BITS_DEF,
  parameter int TAG_BITS      = TAG_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bpq_in_if.sink     in_ch,
  bpq_out_if.source  out_ch,
  bpq_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  logic [CW-1:0]            count_r, count_nxt;
  logic [CAP_W-1:0]         cap_r;
  logic                     out_valid_r;
  status_t                  status_r, status_nxt;
  logic [TAG_BITS-1:0]      otag_r, otag_nxt;
  logic [PRIORITY_BITS-1:0] opri_r, opri_nxt;
  logic [COUNT_W-1:0]       ocnt_r;

  logic in_fire, is_rem, full, do_ins, do_rem;

  logic [PRIORITY_BITS-1:0] cell_pri [DEPTH];
  logic [TAG_BITS-1:0]      cell_tag [DEPTH];
  logic [DEPTH-1:0]         cell_ge;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign is_rem       = (in_ch.opcode == OP_REMOVE);

  // capacity saturates at DEPTH; a lowered capacity below the count rejects inserts
  assign full   = (XW'(count_r) >= XW'(cap_r)) || (count_r == CW'(DEPTH));
  assign do_ins = in_fire && !is_rem && !full;
  assign do_rem = in_fire && is_rem && (count_r != '0);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_t               ctrl;
      logic [PRIORITY_BITS-1:0] lpri, rpri;
      logic [TAG_BITS-1:0]      ltag, rtag;

      assign ctrl.ins      = do_ins;
      assign ctrl.rem      = do_rem;
      assign ctrl.occ      = (CW'(i) < count_r);
      assign ctrl.left_occ = (CW'(i) <= count_r);
      assign ctrl.first    = (i == 0);

      if (i == 0) begin : g_head
        assign ctrl.left_ge = 1'b0;
        assign lpri = '0;
        assign ltag = '0;
      end else begin : g_mid
        assign ctrl.left_ge = cell_ge[i-1];
        assign lpri = cell_pri[i-1];
        assign ltag = cell_tag[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign rpri = '0;
        assign rtag = '0;
      end else begin : g_inner
        assign rpri = cell_pri[i+1];
        assign rtag = cell_tag[i+1];
      end

      bpq_cell #(
        .PRI_W (PRIORITY_BITS),
        .TAG_W (TAG_BITS)
      ) u_cell (
        .clk       (clk),
        .en        (in_fire),
        .ctrl      (ctrl),
        .new_pri   (in_ch.entry_priority),
        .new_tag   (in_ch.entry_tag),
        .left_pri  (lpri),
        .left_tag  (ltag),
        .right_pri (rpri),
        .right_tag (rtag),
        .pri       (cell_pri[i]),
        .tag       (cell_tag[i]),
        .ge        (cell_ge[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    otag_nxt   = '0;
    opri_nxt   = '0;
    if (is_rem) begin
      if (count_r == '0) begin
        status_nxt = ST_EMPTY;
      end else begin
        otag_nxt  = cell_tag[0];
        opri_nxt  = cell_pri[0];
        count_nxt = count_r - CW'(1);
      end
    end else if (full) begin
      status_nxt = ST_FULL;
    end else begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        cap_r <= cfg_ch.data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      otag_r   <= otag_nxt;
      opri_r   <= opri_nxt;
      ocnt_r   <= COUNT_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_tag      = otag_r;
  assign out_ch.out_priority = opri_r;
  assign out_ch.entry_count  = ocnt_r;

  // count stays within the chain
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // an accepted insert that fits grows the count by one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_ins |=> count_r == $past(count_r) + CW'(1))
    else $error("insert did not grow the count");

  // a remove that finds nothing reports an empty queue with zero payload
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_rem && count_r == '0) |=>
      (status_r == ST_EMPTY && otag_r == '0 && opri_r == '0 && count_r == '0))
    else $error("empty remove reported wrongly");

  // a full status never changes the count
  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !is_rem && full) |=> count_r == $past(count_r))
    else $error("rejected insert changed the count");

endmodule

// ----- tb/sv/bpq_order_checker.sv -----
// ----------------------------------------------------------------------------
// bpq_order_checker: result checker for the bounded priority queue
// Watches the operation, result and capacity channels and keeps its own copy
// of the slot row and count. It predicts the result of every accepted
// operation and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bpq_order_checker import bpq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  bpq_in_if     in_ch,
  bpq_out_if    out_ch,
  bpq_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending,
  output int    op_count,
  output int    served_count,
  output int    reject_count,
  output int    empty_count,
  output int    peak_held
);

  localparam int DEPTH = DEPTH_DEF;
  localparam int PRI_W = PRI_BITS_DEF;
  localparam int TAG_W = TAG_BITS_DEF;

  typedef struct packed {
    status_t            status;
    logic [TAG_W-1:0]   tag;
    logic [PRI_W-1:0]   pri;
    logic [COUNT_W-1:0] count;
  } queue_result_t;

  logic [PRI_W-1:0] slot_pri [DEPTH];
  logic [TAG_W-1:0] slot_tag [DEPTH];
  int               held;
  logic [CAP_W-1:0] capacity;

  queue_result_t outcome_fifo [$];
  queue_result_t want;
  queue_result_t got;

  // One queue operation on the shadow slot row, slot 0 served next.
  function automatic queue_result_t apply_queue_op(op_t op, logic [PRI_W-1:0] pri,
                                                   logic [TAG_W-1:0] tag);
    queue_result_t res;
    int            cap_eff;
    int            pos;
    bit            found;
    res.status = ST_DONE;
    res.tag    = '0;
    res.pri    = '0;
    cap_eff    = (int'(capacity) > DEPTH) ? DEPTH : int'(capacity);
    found      = 1'b0;
    if (op == OP_INSERT) begin
      if (held >= cap_eff) begin
        res.status = ST_FULL;
      end else begin
        // behind every entry of greater or equal priority
        pos = held;
        for (int i = 0; i < held; i++) begin
          if (!found && slot_pri[i] < pri) begin
            pos   = i;
            found = 1'b1;
          end
        end
        for (int i = held; i > pos; i--) begin
          slot_pri[i] = slot_pri[i-1];
          slot_tag[i] = slot_tag[i-1];
        end
        slot_pri[pos] = pri;
        slot_tag[pos] = tag;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.tag = slot_tag[0];
        res.pri = slot_pri[0];
        for (int i = 1; i < held; i++) begin
          slot_pri[i-1] = slot_pri[i];
          slot_tag[i-1] = slot_tag[i];
        end
        held--;
      end
    end
    res.count = COUNT_W'(held);
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held         = 0;
      capacity     = CAP_RESET;
      outcome_fifo.delete();
      fail_count   = 0;
      op_count     = 0;
      served_count = 0;
      reject_count = 0;
      empty_count  = 0;
      peak_held    = 0;
    end else begin
      // result first: it always belongs to an earlier transaction
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_fifo.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing outstanding, expected none actual %0h %0h %0h %0h",
                   $time, out_ch.status, out_ch.out_tag, out_ch.out_priority,
                   out_ch.entry_count);
        end else begin
          want = outcome_fifo.pop_front();
          check_field("status", 32'(want.status), 32'(out_ch.status));
          check_field("out_tag", 32'(want.tag), 32'(out_ch.out_tag));
          check_field("out_priority", 32'(want.pri), 32'(out_ch.out_priority));
          check_field("entry_count", 32'(want.count), 32'(out_ch.entry_count));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready)
        capacity = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        got = apply_queue_op(op_t'(in_ch.opcode), in_ch.entry_priority, in_ch.entry_tag);
        outcome_fifo.push_back(got);
        op_count++;
        if (got.status == ST_FULL) reject_count++;
        if (got.status == ST_EMPTY) empty_count++;
        if (got.status == ST_DONE && op_t'(in_ch.opcode) == OP_REMOVE) served_count++;
        if (held > peak_held) peak_held = held;
      end
    end
    pending = outcome_fifo.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level for the bounded priority queue
// Drives operations and capacity writes with random gaps and output stalls,
// including one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import bpq_pkg::*;

  localparam int PRI_W        = PRI_BITS_DEF;
  localparam int TAG_W        = TAG_BITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DIR_INSERTS  = 11;

  logic clk;
  logic rst_n;

  int fail_count;
  int pending;
  int op_count;
  int served_count;
  int reject_count;
  int empty_count;
  int peak_held;
  int cycle_count = 0;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  // equal priorities and both extremes; the eleventh insert finds the queue full
  logic [PRI_W-1:0] dir_pri [DIR_INSERTS] = '{15'd0, 15'h7FFF, 15'd100, 15'd100, 15'd100,
                                              15'h7FFF, 15'd0, 15'd50, 15'd5000, 15'd100,
                                              15'd1};
  logic [TAG_W-1:0] dir_tag [DIR_INSERTS] = '{32'h0, 32'hFFFF_FFFF, 32'hA, 32'hB, 32'hC,
                                              32'h1, 32'h2, 32'h5555_AAAA, 32'hAAAA_5555,
                                              32'hD, 32'hE};

  bpq_in_if  in_ch();
  bpq_out_if out_ch();
  bpq_cfg_if cfg_ch();

  bounded_priority_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bpq_order_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .op_count     (op_count),
    .served_count (served_count),
    .reject_count (reject_count),
    .empty_count  (empty_count),
    .peak_held    (peak_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_op(op_t op, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag);
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= op;
    in_ch.entry_priority <= pri;
    in_ch.entry_tag      <= tag;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  // only while nothing is in flight
  task automatic write_capacity(logic [CAP_W-1:0] value);
    idle_cycles(1);
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random(int insert_pct, int pri_hi);
    logic [PRI_W-1:0] pri;
    op_t              op;
    int               pick;
    op   = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       pri = '0;
      1:       pri = '1;
      2:       pri = PRI_W'($urandom);
      default: pri = PRI_W'($urandom_range(0, pri_hi));
    endcase
    send_op(op, pri, $urandom);
    if (!calm && $urandom_range(0, 4) == 0)
      idle_cycles($urandom_range(1, 5));
  endtask

  task automatic run_phase(logic [CAP_W-1:0] cap, int n, int insert_pct, int pri_hi,
                           bit with_hold);
    write_capacity(cap);
    for (int i = 0; i < n; i++) begin
      if (with_hold && i == n / 2)
        hold_req = 1'b1;
      send_random(insert_pct, pri_hi);
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = OP_INSERT;
    in_ch.entry_priority = '0;
    in_ch.entry_tag      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset capacity: empty remove, extremes, ties, full, drain
    send_op(OP_REMOVE, '1, '1);
    for (int i = 0; i < DIR_INSERTS; i++)
      send_op(OP_INSERT, dir_pri[i], dir_tag[i]);
    for (int i = 0; i < DIR_INSERTS; i++)
      send_op(OP_REMOVE, PRI_W'($urandom), $urandom);

    run_phase(5'd10, 150, 60, 7, 1'b0);
    run_phase(5'd0, 60, 50, 7, 1'b0);
    run_phase(5'd1, 150, 55, 3, 1'b0);
    run_phase(5'd16, 250, 65, 15, 1'b1);
    run_phase(5'd31, 250, 60, 32767, 1'b0);
    // top it off so the next, lower capacity starts below the stored count
    for (int i = 0; i < 16; i++)
      send_op(OP_INSERT, PRI_W'($urandom_range(0, 7)), $urandom);
    run_phase(5'd3, 150, 45, 7, 1'b0);
    run_phase(5'd16, 250, 40, 1, 1'b0);
    run_phase(5'd7, 200, 55, 7, 1'b0);
    run_phase(5'd2, 150, 50, 3, 1'b0);
    calm = 1'b1;
    run_phase(5'd10, 250, 50, 7, 1'b0);

    idle_cycles(1);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    $display("%0d operations: %0d entries served, %0d inserts rejected full, %0d empty removes",
             op_count, served_count, reject_count, empty_count);
    $display("capacities 10 0 1 16 31 3 7 2, one lowered below the stored count; peak fill %0d",
             peak_held);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
